FILE: design/srtf_pkg.sv
// ----------------------------------------------------------------------------
// SRTF ready queue package
// Shared constants, command and status codes, and the types that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package srtf_pkg;

  localparam int DEPTH       = 16;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int COUNT_OUT_W = 5;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [7:0]  proc_id;
    logic [15:0] remaining_time;
    logic [7:0]  burst_remaining;
  } entry_t;

  // Operation the datapath performs on the current cycle.
  typedef struct packed {
    logic ins;
    logic pop;
    logic clr;
  } dp_cmd_t;

  // Queue condition reported back to the controller.
  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

FILE: design/srtf_in_if.sv
// ----------------------------------------------------------------------------
// SRTF ready queue command channel
// Valid/ready channel that carries one queue command per transaction.
// ----------------------------------------------------------------------------
interface srtf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  proc_id;
  logic [15:0] remaining_time;
  logic [7:0]  burst_remaining;

  modport source (
    output valid, cmd, proc_id, remaining_time, burst_remaining,
    input  ready
  );
  modport sink (
    input  valid, cmd, proc_id, remaining_time, burst_remaining,
    output ready
  );
endinterface

FILE: design/srtf_out_if.sv
// ----------------------------------------------------------------------------
// SRTF ready queue result channel
// Valid/ready channel that carries the head entry, count and status.
// ----------------------------------------------------------------------------
interface srtf_out_if;
  logic        valid;
  logic        ready;
  logic        head_valid;
  logic [7:0]  head_id;
  logic [15:0] head_remaining;
  logic [7:0]  head_burst;
  logic [4:0]  entry_count;
  logic [1:0]  status;

  modport source (
    output valid, head_valid, head_id, head_remaining, head_burst,
           entry_count, status,
    input  ready
  );
  modport sink (
    input  valid, head_valid, head_id, head_remaining, head_burst,
           entry_count, status,
    output ready
  );
endinterface

FILE: design/srtf_ready_queue.sv
// ----------------------------------------------------------------------------
// SRTF ready queue
// Bounded sorted ready queue for a shortest-remaining-time scheduler.
// ----------------------------------------------------------------------------
// Usage: each transaction on in_ch carries one command: insert a process,
// pop the head, or clear the queue. Entries stay sorted by total remaining
// time, with the burst remaining time breaking ties; a new entry goes behind
// entries with an equal key. Every command gives exactly one transaction on
// out_ch with the head entry, the entry count after the command, and a
// status: ok, insert dropped because the queue is full, or pop on empty.
// The result is valid on the cycle after the command is taken. Throughput
// is one command per cycle while the result is drained; the queue slots
// compare their keys with the new entry in parallel and all shift at once.
// The result sits in an output register, and a new command is taken
// whenever that register is empty or being drained in the same cycle. When
// the receiver stalls, the result holds and in_ch.ready drops until it is
// taken. Reset empties the queue and clears the result register; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module srtf_ready_queue (
  input  logic      clk,
  input  logic      rst_n,
  srtf_in_if.sink   in_ch,
  srtf_out_if.source out_ch
);

  srtf_pkg::dp_cmd_t             dp_cmd;
  srtf_pkg::dp_stat_t            dp_stat;
  srtf_pkg::entry_t              new_entry;
  srtf_pkg::entry_t              head;
  logic                          head_valid;
  logic [srtf_pkg::CNT_W-1:0]    count;

  assign new_entry.proc_id         = in_ch.proc_id;
  assign new_entry.remaining_time  = in_ch.remaining_time;
  assign new_entry.burst_remaining = in_ch.burst_remaining;

  // Handshakes, command decode and the status of the last transaction.
  srtf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_cmd    (in_ch.cmd),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (out_ch.status),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat)
  );

  // Sorted slots and occupancy. The head and count come straight from
  // registers and only change when a new command is taken.
  srtf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .dp_cmd     (dp_cmd),
    .dp_stat    (dp_stat),
    .new_entry  (new_entry),
    .head_valid (head_valid),
    .head       (head),
    .count      (count)
  );

  assign out_ch.head_valid     = head_valid;
  assign out_ch.head_id        = head.proc_id;
  assign out_ch.head_remaining = head.remaining_time;
  assign out_ch.head_burst     = head.burst_remaining;
  // The count field is fixed at five bits whatever the queue depth.
  assign out_ch.entry_count    = srtf_pkg::COUNT_OUT_W'(count);

endmodule

FILE: design/srtf_ctrl.sv
// ----------------------------------------------------------------------------
// SRTF ready queue controller
// Handles both handshakes, decodes commands into datapath operations and
// keeps the status of the last command.
// ----------------------------------------------------------------------------
module srtf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output srtf_pkg::dp_cmd_t  dp_cmd,
  input  srtf_pkg::dp_stat_t dp_stat
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic       state_r, state_nxt;
  logic [1:0] status_r, status_nxt;
  logic       accept;

  // A waiting result that is taken this cycle frees the output register.
  assign in_ready  = (state_r == S_IDLE) || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = (state_r == S_HOLD);
  assign status    = status_r;

  always_comb begin
    dp_cmd     = '0;
    status_nxt = status_r;
    if (accept) begin
      status_nxt = srtf_pkg::STATUS_OK;
      unique case (in_cmd)
        srtf_pkg::CMD_INSERT: begin
          if (dp_stat.full) status_nxt = srtf_pkg::STATUS_FULL;
          else              dp_cmd.ins = 1'b1;
        end
        srtf_pkg::CMD_POP: begin
          if (dp_stat.empty) status_nxt = srtf_pkg::STATUS_EMPTY;
          else               dp_cmd.pop = 1'b1;
        end
        srtf_pkg::CMD_CLEAR: dp_cmd.clr = 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_HOLD;
      S_HOLD: if (out_ready && !accept) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= srtf_pkg::STATUS_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted command produced no result");

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({dp_cmd.ins, dp_cmd.pop, dp_cmd.clr}))
    else $error("more than one datapath operation issued");

  a_op_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.ins || dp_cmd.pop || dp_cmd.clr) |-> accept)
    else $error("datapath operation issued without an accepted command");
`endif

endmodule

FILE: design/srtf_dp.sv
// ----------------------------------------------------------------------------
// SRTF ready queue datapath
// Sorted shift-register queue: every slot compares its key with the new
// entry in parallel, and slots shift up on insert and down on pop.
// ----------------------------------------------------------------------------
module srtf_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  srtf_pkg::dp_cmd_t            dp_cmd,
  output srtf_pkg::dp_stat_t           dp_stat,
  input  srtf_pkg::entry_t             new_entry,
  output logic                         head_valid,
  output srtf_pkg::entry_t             head,
  output logic [srtf_pkg::CNT_W-1:0]   count
);

  srtf_pkg::entry_t            entries_r   [srtf_pkg::DEPTH];
  srtf_pkg::entry_t            entries_nxt [srtf_pkg::DEPTH];
  logic [srtf_pkg::CNT_W-1:0]  occ_r, occ_nxt;
  logic [srtf_pkg::DEPTH-1:0]  after_new;

  // A slot lies behind the new entry when it is unused or its key is
  // strictly larger; equal keys keep the new entry behind them.
  for (genvar i = 0; i < srtf_pkg::DEPTH; i++) begin : g_slot
    srtf_pkg::entry_t below;
    srtf_pkg::entry_t above;
    logic             below_after;

    assign after_new[i] = (srtf_pkg::CNT_W'(i) >= occ_r) ||
      ({entries_r[i].remaining_time, entries_r[i].burst_remaining} >
       {new_entry.remaining_time, new_entry.burst_remaining});

    if (i == 0) begin : g_bottom
      assign below       = new_entry;
      assign below_after = 1'b0;
    end else begin : g_lower
      assign below       = entries_r[i - 1];
      assign below_after = after_new[i - 1];
    end

    if (i == srtf_pkg::DEPTH - 1) begin : g_top
      assign above = entries_r[i];
    end else begin : g_upper
      assign above = entries_r[i + 1];
    end

    // When the slot below also moves back, its entry shifts up into this
    // one; otherwise this is where the new entry lands.
    always_comb begin
      entries_nxt[i] = entries_r[i];
      if (dp_cmd.ins && after_new[i]) begin
        entries_nxt[i] = below_after ? below : new_entry;
      end else if (dp_cmd.pop) begin
        entries_nxt[i] = above;
      end
    end

    always_ff @(posedge clk) begin
      entries_r[i] <= entries_nxt[i];
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    if (dp_cmd.clr)      occ_nxt = '0;
    else if (dp_cmd.ins) occ_nxt = occ_r + 1'b1;
    else if (dp_cmd.pop) occ_nxt = occ_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) occ_r <= '0;
    else        occ_r <= occ_nxt;
  end

  assign dp_stat.full  = (occ_r == srtf_pkg::CNT_W'(srtf_pkg::DEPTH));
  assign dp_stat.empty = (occ_r == '0);
  assign head_valid    = !dp_stat.empty;
  assign head          = head_valid ? entries_r[0] : '0;
  assign count         = occ_r;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= srtf_pkg::CNT_W'(srtf_pkg::DEPTH))
    else $error("occupancy above queue depth");

  a_ins_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.ins |-> !dp_stat.full)
    else $error("insert issued on a full queue");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.ins |=> occ_r == srtf_pkg::CNT_W'($past(occ_r) + 1'b1))
    else $error("insert did not grow the queue by one");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.pop && !dp_stat.empty) |=>
      occ_r == srtf_pkg::CNT_W'($past(occ_r) - 1'b1))
    else $error("pop did not shrink the queue by one");
`endif

endmodule

FILE: test/srtf_ready_queue_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SRTF ready queue testbench
// Drives queue commands with random idle gaps and result back-pressure, and
// checks every returned head/count/status transaction against a sorted
// queue predictor kept in the testbench.
// ----------------------------------------------------------------------------
module srtf_ready_queue_test;

  // Command code 3 has no meaning; the block must leave the queue alone.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_PER_PHASE = 140;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES     = 10;

  // Idle and stall percentages for the four random phases: free running,
  // sparse commands, heavy back-pressure, and a light mix of both.
  localparam int SENDER_IDLE_PLAN [4]   = '{0, 72, 0, 20};
  localparam int RECEIVER_STALL_PLAN [4] = '{0, 0, 72, 20};

  // One result transaction as it appears on the result channel.
  typedef struct packed {
    logic        head_valid;
    logic [7:0]  head_id;
    logic [15:0] head_remaining;
    logic [7:0]  head_burst;
    logic [4:0]  entry_count;
    logic [1:0]  status;
  } queue_report_t;

  // One row of the directed table. A row is issued reps times, with the
  // process id stepping by one on each repetition. Where pinned is set, the
  // result is the one typed into the row rather than the predicted one.
  typedef struct packed {
    logic [1:0]    cmd;
    logic [7:0]    id;
    logic [15:0]   rem;
    logic [7:0]    burst;
    logic [4:0]    reps;
    logic          pinned;
    queue_report_t want;
  } stim_row_t;

  localparam int N_ROWS = 22;

  // The directed walk: empty-queue cases and the ignored command code,
  // field extremes, equal keys that must stay in arrival order, the burst
  // tie-break, a fill to the brim with an insert that gets dropped, and
  // clears from both a partly filled and a nearly full queue.
  localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
    '{srtf_pkg::CMD_POP,    8'h00, 16'h0000, 8'h00, 5'd1,  1'b1,
      '{1'b0, 8'h00, 16'h0000, 8'h00, 5'd0, srtf_pkg::STATUS_EMPTY}},
    '{srtf_pkg::CMD_CLEAR,  8'h00, 16'h0000, 8'h00, 5'd1,  1'b1,
      '{1'b0, 8'h00, 16'h0000, 8'h00, 5'd0, srtf_pkg::STATUS_OK}},
    '{CMD_UNUSED,           8'hFF, 16'hFFFF, 8'hFF, 5'd1,  1'b1,
      '{1'b0, 8'h00, 16'h0000, 8'h00, 5'd0, srtf_pkg::STATUS_OK}},
    '{srtf_pkg::CMD_INSERT, 8'hFF, 16'hFFFF, 8'hFF, 5'd1,  1'b1,
      '{1'b1, 8'hFF, 16'hFFFF, 8'hFF, 5'd1, srtf_pkg::STATUS_OK}},
    '{srtf_pkg::CMD_INSERT, 8'h00, 16'h0000, 8'h00, 5'd1,  1'b1,
      '{1'b1, 8'h00, 16'h0000, 8'h00, 5'd2, srtf_pkg::STATUS_OK}},
    '{srtf_pkg::CMD_INSERT, 8'h07, 16'h0000, 8'h00, 5'd1,  1'b1,
      '{1'b1, 8'h00, 16'h0000, 8'h00, 5'd3, srtf_pkg::STATUS_OK}},
    '{srtf_pkg::CMD_POP,    8'h00, 16'h0000, 8'h00, 5'd2,  1'b0, '0},
    '{srtf_pkg::CMD_INSERT, 8'hAA, 16'h0064, 8'h05, 5'd1,  1'b0, '0},
    '{srtf_pkg::CMD_INSERT, 8'h55, 16'h0064, 8'h04, 5'd1,  1'b0, '0},
    '{srtf_pkg::CMD_INSERT, 8'h5A, 16'h0063, 8'hFF, 5'd1,  1'b0, '0},
    '{srtf_pkg::CMD_INSERT, 8'hA5, 16'h0064, 8'h04, 5'd1,  1'b0, '0},
    '{srtf_pkg::CMD_POP,    8'h00, 16'h0000, 8'h00, 5'd2,  1'b0, '0},
    '{srtf_pkg::CMD_INSERT, 8'h10, 16'h1234, 8'h0F, 5'd14, 1'b0, '0},
    '{srtf_pkg::CMD_INSERT, 8'h3C, 16'h0000, 8'h00, 5'd1,  1'b1,
      '{1'b1, 8'hA5, 16'h0064, 8'h04, 5'd16, srtf_pkg::STATUS_FULL}},
    '{CMD_UNUSED,           8'h00, 16'h0000, 8'h00, 5'd1,  1'b0, '0},
    '{srtf_pkg::CMD_POP,    8'h00, 16'h0000, 8'h00, 5'd3,  1'b0, '0},
    '{srtf_pkg::CMD_INSERT, 8'h3C, 16'h0000, 8'h00, 5'd1,  1'b0, '0},
    '{srtf_pkg::CMD_CLEAR,  8'h00, 16'h0000, 8'h00, 5'd1,  1'b1,
      '{1'b0, 8'h00, 16'h0000, 8'h00, 5'd0, srtf_pkg::STATUS_OK}},
    '{srtf_pkg::CMD_POP,    8'h00, 16'h0000, 8'h00, 5'd1,  1'b1,
      '{1'b0, 8'h00, 16'h0000, 8'h00, 5'd0, srtf_pkg::STATUS_EMPTY}},
    '{srtf_pkg::CMD_INSERT, 8'h81, 16'h0001, 8'h80, 5'd1,  1'b1,
      '{1'b1, 8'h81, 16'h0001, 8'h80, 5'd1, srtf_pkg::STATUS_OK}},
    '{srtf_pkg::CMD_INSERT, 8'h7E, 16'hFFFE, 8'h7F, 5'd1,  1'b0, '0},
    '{srtf_pkg::CMD_CLEAR,  8'h00, 16'h0000, 8'h00, 5'd1,  1'b1,
      '{1'b0, 8'h00, 16'h0000, 8'h00, 5'd0, srtf_pkg::STATUS_OK}}
  };

  logic clk;
  logic rst_n;

  srtf_in_if  in_ch ();
  srtf_out_if out_ch ();

  srtf_ready_queue u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: a sorted copy of the ready queue and its fill level.
  srtf_pkg::entry_t sorted_slots [srtf_pkg::DEPTH];
  int               slots_used;

  // Results owed by the block, oldest first.
  queue_report_t reports_due [$];

  // The sender marks a transaction whose result is typed into the table.
  logic          pin_on;
  queue_report_t pin_want;

  int sender_idle_pct;
  int receiver_stall_pct;
  int fail_count;
  int quiet_cycles;

  // Figures for the closing summary.
  int n_inserts;
  int n_pops;
  int n_clears;
  int n_dropped;
  int n_empty_pops;
  int n_checked;
  int peak_fill;

  queue_report_t predicted;
  queue_report_t observed;
  queue_report_t oldest;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Applies one command to the predictor's queue and returns the result
  // the block owes for it. Ordering is on the 24-bit key formed by the
  // total remaining time above the burst remaining time; a new entry is
  // placed behind every entry whose key is not greater than its own.
  function automatic queue_report_t apply_sched_cmd(input logic [1:0] cmd,
                                                    input srtf_pkg::entry_t item);
    queue_report_t rep;
    logic [23:0]   new_key;
    int            pos;
    rep = '0;
    rep.status = srtf_pkg::STATUS_OK;
    new_key = {item.remaining_time, item.burst_remaining};
    case (cmd)
      srtf_pkg::CMD_INSERT: begin
        if (slots_used >= srtf_pkg::DEPTH) begin
          rep.status = srtf_pkg::STATUS_FULL;
        end else begin
          pos = 0;
          while (pos < slots_used &&
                 {sorted_slots[pos].remaining_time,
                  sorted_slots[pos].burst_remaining} <= new_key)
            pos++;
          for (int i = slots_used; i > pos; i--)
            sorted_slots[i] = sorted_slots[i - 1];
          sorted_slots[pos] = item;
          slots_used++;
        end
      end
      srtf_pkg::CMD_POP: begin
        if (slots_used == 0) begin
          rep.status = srtf_pkg::STATUS_EMPTY;
        end else begin
          for (int i = 1; i < slots_used; i++)
            sorted_slots[i - 1] = sorted_slots[i];
          slots_used--;
        end
      end
      srtf_pkg::CMD_CLEAR: begin
        slots_used = 0;
      end
      default: begin
        // The unused code leaves the queue as it is.
      end
    endcase
    // Slots at or above the fill level are never read, so stale contents
    // left behind by a pop or a clear cannot leak into a result.
    if (slots_used > 0) begin
      rep.head_valid     = 1'b1;
      rep.head_id        = sorted_slots[0].proc_id;
      rep.head_remaining = sorted_slots[0].remaining_time;
      rep.head_burst     = sorted_slots[0].burst_remaining;
    end
    rep.entry_count = slots_used[4:0];
    return rep;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
               $time, name, want, got);
      fail_count++;
    end
  endtask

  // Keys are drawn half the time from a narrow range so that equal keys and
  // burst tie-breaks are common, with some full-range and some extreme ones.
  function automatic srtf_pkg::entry_t random_entry();
    srtf_pkg::entry_t e;
    int               shape;
    shape = $urandom_range(0, 9);
    e.proc_id = 8'($urandom_range(0, 255));
    if (shape < 5) begin
      e.remaining_time  = 16'($urandom_range(0, 15));
      e.burst_remaining = 8'($urandom_range(0, 3));
    end else if (shape < 8) begin
      e.remaining_time  = 16'($urandom_range(0, 65535));
      e.burst_remaining = 8'($urandom_range(0, 255));
    end else begin
      e.remaining_time  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      e.burst_remaining = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return e;
  endfunction

  // Mix 0 fills the queue, mix 1 drains it, mix 2 keeps it hovering.
  // Clears and the unused code are kept rare so that the queue gets deep.
  function automatic logic [1:0] random_cmd(input int mix);
    int roll;
    int ins_cut;
    int pop_cut;
    roll = $urandom_range(0, 99);
    case (mix)
      0:       begin ins_cut = 75; pop_cut = 94; end
      1:       begin ins_cut = 25; pop_cut = 94; end
      default: begin ins_cut = 48; pop_cut = 94; end
    endcase
    if (roll < ins_cut) return srtf_pkg::CMD_INSERT;
    if (roll < pop_cut) return srtf_pkg::CMD_POP;
    if (roll < 97)      return srtf_pkg::CMD_CLEAR;
    return CMD_UNUSED;
  endfunction

  // Presents one command transaction. Called at a falling edge; returns at
  // the falling edge after the transaction was accepted. Idle cycles before
  // the transaction keep valid low, so valid gets one update per edge.
  task automatic send_cmd(input logic [1:0] cmd, input srtf_pkg::entry_t item,
                          input logic pin, input queue_report_t want);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.cmd             <= cmd;
    in_ch.proc_id         <= item.proc_id;
    in_ch.remaining_time  <= item.remaining_time;
    in_ch.burst_remaining <= item.burst_remaining;
    pin_on   = pin;
    pin_want = want;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
  endtask

  // The receiver decides at each falling edge whether to stall the next
  // rising edge.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // Monitor: every accepted command updates the predictor and queues the
  // result it owes; every accepted result is compared with the oldest one
  // owed. Prediction comes first so that a result could never be checked
  // ahead of the command that caused it.
  always @(posedge clk) begin
    if (rst_n) begin
      if ($isunknown({in_ch.ready, out_ch.valid})) begin
        $display("%0t: handshake signal unknown, in ready %b, out valid %b",
                 $time, in_ch.ready, out_ch.valid);
        fail_count++;
      end
      if (in_ch.valid && in_ch.ready) begin
        predicted = apply_sched_cmd(in_ch.cmd,
                                    '{in_ch.proc_id, in_ch.remaining_time,
                                      in_ch.burst_remaining});
        reports_due.push_back(pin_on ? pin_want : predicted);
        case (in_ch.cmd)
          srtf_pkg::CMD_INSERT: n_inserts++;
          srtf_pkg::CMD_POP:    n_pops++;
          srtf_pkg::CMD_CLEAR:  n_clears++;
          default:    ;
        endcase
        if (predicted.status == srtf_pkg::STATUS_FULL)  n_dropped++;
        if (predicted.status == srtf_pkg::STATUS_EMPTY) n_empty_pops++;
        if (slots_used > peak_fill) peak_fill = slots_used;
      end
      if (out_ch.valid && out_ch.ready) begin
        observed = '{out_ch.head_valid, out_ch.head_id, out_ch.head_remaining,
                     out_ch.head_burst, out_ch.entry_count, out_ch.status};
        if (reports_due.size() == 0) begin
          $display("%0t: result transaction with nothing pending, expected none, got 0x%0h",
                   $time, observed);
          fail_count++;
        end else begin
          oldest = reports_due.pop_front();
          check_field("head_valid",     oldest.head_valid,     observed.head_valid);
          check_field("head_id",        oldest.head_id,        observed.head_id);
          check_field("head_remaining", oldest.head_remaining, observed.head_remaining);
          check_field("head_burst",     oldest.head_burst,     observed.head_burst);
          check_field("entry_count",    oldest.entry_count,    observed.entry_count);
          check_field("status",         oldest.status,         observed.status);
          n_checked++;
        end
      end
    end
  end

  // Watchdog: a run that moves no transaction on either channel for too
  // long is hung.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results still owed",
               $time, WATCHDOG_LIMIT, reports_due.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int         counted;
    int         mix;
    logic [1:0] cmd;
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.cmd             <= srtf_pkg::CMD_INSERT;
    in_ch.proc_id         <= 8'h00;
    in_ch.remaining_time  <= 16'h0000;
    in_ch.burst_remaining <= 8'h00;
    pin_on             = 1'b0;
    pin_want           = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    slots_used         = 0;
    fail_count         = 0;
    quiet_cycles       = 0;
    n_inserts          = 0;
    n_pops             = 0;
    n_clears           = 0;
    n_dropped          = 0;
    n_empty_pops       = 0;
    n_checked          = 0;
    peak_fill          = 0;
    mix                = 2;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed walk, at full rate on both sides.
    foreach (DIRECTED_ROWS[r])
      for (int k = 0; k < DIRECTED_ROWS[r].reps; k++)
        send_cmd(DIRECTED_ROWS[r].cmd,
                 '{DIRECTED_ROWS[r].id + 8'(k), DIRECTED_ROWS[r].rem,
                   DIRECTED_ROWS[r].burst},
                 DIRECTED_ROWS[r].pinned, DIRECTED_ROWS[r].want);

    // Random part. The fill/drain mix is redrawn every few dozen commands
    // so that the queue swings between empty and full within each phase.
    // Transactions with the unused code do not count toward a phase.
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct    = SENDER_IDLE_PLAN[ph];
      receiver_stall_pct = RECEIVER_STALL_PLAN[ph];
      counted = 0;
      while (counted < RANDOM_PER_PHASE) begin
        if (counted % 40 == 0) mix = $urandom_range(0, 2);
        cmd = random_cmd(mix);
        if (cmd != CMD_UNUSED) counted++;
        send_cmd(cmd, random_entry(), 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    // Keep running to catch any result the block should not produce.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d inserts (%0d dropped on a full queue), %0d pops (%0d on empty),",
             n_inserts, n_dropped, n_pops, n_empty_pops);
    $display("%0d clears; queue depth peaked at %0d; %0d results compared.",
             n_clears, peak_fill, n_checked);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
